/* design/q16d_pkg.sv */
package q16d_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned FracW = 16;
	localparam int unsigned WideW = DataW + FracW + 1;
	localparam int unsigned Steps = DataW;

	localparam logic [DataW-1:0] QOne    = 32'h0001_0000;
	localparam logic [DataW-1:0] QIntMsk = 32'hffff_0000;
	localparam logic [DataW-1:0] UMaxRaw = 32'hffff_ffff;
	localparam logic [DataW-1:0] SMaxRaw = 32'h7fff_ffff;
	localparam logic [DataW-1:0] SMinRaw = 32'h8000_0000;

	typedef enum logic {
		OP_SIGNED   = 1'b0,
		OP_UNSIGNED = 1'b1
	} q16d_op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SAT     = 2'd1,
		ST_DIVZERO = 2'd2
	} q16d_status_t;

	// per-item flags carried down the pipe
	typedef struct packed {
		q16d_op_t op;
		logic     neg;   // result sign in signed mode
		logic     nneg;  // dividend sign, picks divide-by-zero saturation
		logic     dz;
		logic     ovf;   // quotient >= 2^32
	} q16d_side_t;

	typedef struct packed {
		logic [DataW-1:0] rem;
		logic [DataW-1:0] bits;  // dividend bits in, quotient bits out
		logic [DataW-1:0] den;
		q16d_side_t       side;
	} q16d_div_t;

endpackage

/* design/q16d_if.sv */
interface q16d_req_if;
	import q16d_pkg::*;

	logic             valid;
	logic             ready;
	logic             operation;
	logic [DataW-1:0] dividend;
	logic [DataW-1:0] divisor;

	modport source (output valid, operation, dividend, divisor, input ready);
	modport sink (input valid, operation, dividend, divisor, output ready);
endinterface

interface q16d_rsp_if;
	import q16d_pkg::*;

	logic             valid;
	logic             ready;
	logic [DataW-1:0] quotient;
	logic [1:0]       status;

	modport source (output valid, quotient, status, input ready);
	modport sink (input valid, quotient, status, output ready);
endinterface

/* design/q16d_step.sv */
module q16d_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	input  q16d_pkg::q16d_div_t up_data,
	output logic                up_take,
	output logic                dn_valid,
	output q16d_pkg::q16d_div_t dn_data,
	input  logic                dn_take
);
	import q16d_pkg::*;

	logic                 v_q;
	q16d_div_t            d_q;
	logic [DataW:0]       trial;
	logic [DataW+1:0]     diff;
	logic                 ge;
	q16d_div_t            d_nxt;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {up_data.rem, up_data.bits[DataW-1]};
		diff  = {1'b0, trial} - {2'b00, up_data.den};
		ge    = ~diff[DataW+1];
		d_nxt      = up_data;
		d_nxt.rem  = ge ? diff[DataW-1:0] : trial[DataW-1:0];
		d_nxt.bits = {up_data.bits[DataW-2:0], ge};
	end

	assign up_take = ~v_q | dn_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_take) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_take && up_valid) begin
			d_q <= d_nxt;
		end
	end

	assign dn_valid = v_q;
	assign dn_data  = d_q;
endmodule

/* design/q16_divide_rounding_saturating.sv */
// Q16.16 divide, signed or unsigned, rounded to nearest, saturating.
// Pipeline: 3 setup stages, 32 restoring-division stages of one quotient
// bit each, 1 output stage.
// Throughput: one request per cycle; every stage holds its item on a stall
// and empty stages keep filling. Reset clears all valid bits asynchronously.
module q16_divide_rounding_saturating (
	input logic     clk,
	input logic     arst_n,
	q16d_req_if.sink   req,
	q16d_rsp_if.source rsp
);
	import q16d_pkg::*;

	// stage 1: operand magnitudes
	logic             v_s1;
	q16d_side_t       side_s1;
	logic [DataW-1:0] nmag_s1;
	logic [DataW-1:0] dmag_s1;
	logic             take_s1;

	// stage 2: scaled and rounded dividend
	logic             v_s2;
	q16d_side_t       side_s2;
	logic [WideW-1:0] wide_s2;
	logic [DataW-1:0] dmag_s2;
	logic             take_s2;

	// stage 3 feeds the division chain
	logic             take_s3;
	logic             v_s3;
	q16d_div_t        div_s3;
	q16d_side_t       side_s3;
	logic             v_div    [0:Steps];
	q16d_div_t        div_d    [0:Steps];
	logic             take_div [0:Steps];

	// output stage
	logic             v_out_q;
	logic [DataW-1:0] quot_q;
	q16d_status_t     stat_q;
	logic             take_out;

	logic             in_nneg;
	logic             in_dneg;
	logic [DataW-1:0] res_q;
	q16d_status_t     res_st;
	q16d_div_t        fin;

	assign take_out = ~v_out_q | rsp.ready;
	assign take_div[Steps] = take_out;
	assign take_s3 = ~v_s3 | take_div[0];
	assign take_s2 = ~v_s2 | take_s3;
	assign take_s1 = ~v_s1 | take_s2;
	assign req.ready = take_s1;

	assign in_nneg = (req.operation == OP_SIGNED) && req.dividend[DataW-1];
	assign in_dneg = (req.operation == OP_SIGNED) && req.divisor[DataW-1];

	// quotient >= 2^32 exactly when the top part already reaches den
	always_comb begin
		side_s3     = side_s2;
		side_s3.ovf = ({{(2*DataW-WideW){1'b0}}, wide_s2[WideW-1:DataW]} >= dmag_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_out_q   <= 1'b0;
		end else begin
			if (take_s1) begin
				v_s1 <= req.valid;
			end
			if (take_s2) begin
				v_s2 <= v_s1;
			end
			if (take_s3) begin
				v_s3 <= v_s2;
			end
			if (take_out) begin
				v_out_q <= v_div[Steps];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && req.valid) begin
			side_s1.op   <= q16d_op_t'(req.operation);
			side_s1.nneg <= in_nneg;
			side_s1.neg  <= in_nneg ^ in_dneg;
			side_s1.dz   <= (req.divisor == '0);
			side_s1.ovf  <= 1'b0;
			nmag_s1      <= in_nneg ? (~req.dividend + 1'b1) : req.dividend;
			dmag_s1      <= in_dneg ? (~req.divisor + 1'b1) : req.divisor;
		end
		if (take_s2 && v_s1) begin
			side_s2 <= side_s1;
			dmag_s2 <= dmag_s1;
			// num * 2^16 + floor(den / 2)
			wide_s2 <= {1'b0, nmag_s1, {FracW{1'b0}}} + {{(FracW+1){1'b0}}, 1'b0,
				dmag_s1[DataW-1:1]};
		end
		if (take_s3 && v_s2) begin
			div_s3.rem  <= {{(2*DataW-WideW){1'b0}}, wide_s2[WideW-1:DataW]};
			div_s3.bits <= wide_s2[DataW-1:0];
			div_s3.den  <= dmag_s2;
			div_s3.side <= side_s3;
		end
		if (take_out && v_div[Steps]) begin
			quot_q <= res_q;
			stat_q <= res_st;
		end
	end

	assign v_div[0] = v_s3;
	assign div_d[0] = div_s3;

	for (genvar i = 0; i < Steps; i++) begin : g_step
		q16d_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_valid(v_div[i]),
			.up_data (div_d[i]),
			.up_take (take_div[i]),
			.dn_valid(v_div[i+1]),
			.dn_data (div_d[i+1]),
			.dn_take (take_div[i+1])
		);
	end

	assign fin = div_d[Steps];

	always_comb begin
		res_q  = fin.bits;
		res_st = ST_OK;
		unique case (fin.side.op)
			OP_UNSIGNED: begin
				if (fin.side.dz) begin
					res_q  = UMaxRaw;
					res_st = ST_DIVZERO;
				end else if (fin.side.ovf) begin
					res_q  = UMaxRaw;
					res_st = ST_SAT;
				end
			end
			OP_SIGNED: begin
				if (fin.side.dz) begin
					res_q  = fin.side.nneg ? SMinRaw : SMaxRaw;
					res_st = ST_DIVZERO;
				end else if (fin.side.ovf || fin.bits[DataW-1]) begin
					res_q  = fin.side.neg ? SMinRaw : SMaxRaw;
					res_st = ST_SAT;
				end else if (fin.side.neg) begin
					res_q = ~fin.bits + 1'b1;
				end
			end
			default: begin
				res_q  = fin.bits;
				res_st = ST_OK;
			end
		endcase
	end

	assign rsp.valid    = v_out_q;
	assign rsp.quotient = quot_q;
	assign rsp.status   = stat_q;
endmodule

/* design/q16d_checker.sv */
module q16d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] quotient,
	input logic [1:0]  status
);
	import q16d_pkg::*;

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("result valid during reset");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_OK || status == ST_SAT || status == ST_DIVZERO))
		else $error("undefined status code");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != ST_OK) |->
		(quotient == UMaxRaw || quotient == SMaxRaw || quotient == SMinRaw))
		else $error("saturated result is not a saturation value");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(quotient) && $stable(status)))
		else $error("stalled result changed");
endmodule

bind q16_divide_rounding_saturating q16d_checker u_q16d_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.quotient (rsp.quotient),
	.status   (rsp.status)
);

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import q16d_pkg::*;

	localparam int RandomItems = 900;
	localparam int DrainAt     = 600;     // random item that waits for an empty pipe
	localparam int TailItems   = 100;     // no idling once this few are left
	localparam int HoldAt      = 300;     // accepted requests before the long hold-off
	localparam int HoldCycles  = 150;     // well past the 36-stage pipe depth
	localparam int FlushCycles = 48;
	localparam int CycleLimit  = 300000;

	typedef struct packed {
		q16d_op_t         op;
		logic [DataW-1:0] dividend;
		logic [DataW-1:0] divisor;
		logic             drain;
	} div_req_t;

	typedef struct packed {
		logic [DataW-1:0] quotient;
		q16d_status_t     status;
	} div_rsp_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b1;

	logic             drv_valid    = 1'b0;
	q16d_op_t         drv_op       = OP_SIGNED;
	logic [DataW-1:0] drv_dividend = '0;
	logic [DataW-1:0] drv_divisor  = '0;
	logic             rsp_ready    = 1'b0;

	q16d_req_if req ();
	q16d_rsp_if rsp ();

	assign req.valid     = drv_valid;
	assign req.operation = drv_op;
	assign req.dividend  = drv_dividend;
	assign req.divisor   = drv_divisor;
	assign rsp.ready     = rsp_ready;

	q16_divide_rounding_saturating u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	div_req_t operand_queue[$];
	div_rsp_t quotient_queue[$];

	int total_items   = 0;
	int accepted_cnt  = 0;
	int result_cnt    = 0;
	int mismatch_cnt  = 0;
	int sat_cnt       = 0;
	int divzero_cnt   = 0;
	int in_stall_cnt  = 0;
	int cycle_cnt     = 0;
	int send_gap      = 0;
	int stall_left    = 0;
	int hold_left     = 0;
	bit hold_done     = 1'b0;
	bit req_taken     = 1'b0;

	always begin
		#4;
		clk = 1'b1;
		#4;
		clk = 1'b0;
	end

	// rounded magnitude divide, sign restored, saturated per mode
	function automatic div_rsp_t rounded_quotient(q16d_op_t op, logic [DataW-1:0] num,
	                                              logic [DataW-1:0] den);
		div_rsp_t         res;
		logic [DataW-1:0] nmag;
		logic [DataW-1:0] dmag;
		logic [63:0]      mag;
		logic             neg;
		if (op == OP_UNSIGNED) begin
			nmag = num;
			dmag = den;
			neg  = 1'b0;
		end else begin
			nmag = num[DataW-1] ? -num : num;
			dmag = den[DataW-1] ? -den : den;
			neg  = num[DataW-1] ^ den[DataW-1];
		end
		if (den == '0) begin
			res.status = ST_DIVZERO;
			if (op == OP_UNSIGNED)
				res.quotient = UMaxRaw;
			else
				res.quotient = num[DataW-1] ? SMinRaw : SMaxRaw;
		end else begin
			mag = (64'(nmag) << FracW) + 64'(dmag >> 1);
			mag = mag / 64'(dmag);
			if (op == OP_UNSIGNED && mag > 64'(UMaxRaw)) begin
				res.status   = ST_SAT;
				res.quotient = UMaxRaw;
			end else if (op == OP_SIGNED && mag >= 64'(SMinRaw)) begin
				res.status   = ST_SAT;
				res.quotient = neg ? SMinRaw : SMaxRaw;
			end else begin
				res.status   = ST_OK;
				res.quotient = neg ? -mag[DataW-1:0] : mag[DataW-1:0];
			end
		end
		return res;
	endfunction

	function automatic logic [DataW-1:0] random_operand();
		logic [DataW-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom;
			4, 5, 6:    v = $urandom >> $urandom_range(1, 31);
			7: begin
				case ($urandom_range(0, 6))
					0: v = '0;
					1: v = 32'd1;
					2: v = QOne;
					3: v = QIntMsk;
					4: v = SMinRaw;
					5: v = SMaxRaw;
					default: v = UMaxRaw;
				endcase
			end
			8:       v = $urandom_range(1, 4);
			default: v = -($urandom >> $urandom_range(1, 31));
		endcase
		return v;
	endfunction

	task automatic queue_divide(q16d_op_t op, logic [DataW-1:0] num, logic [DataW-1:0] den,
	                            logic drain = 1'b0);
		div_req_t item;
		item.op       = op;
		item.dividend = num;
		item.divisor  = den;
		item.drain    = drain;
		operand_queue.push_back(item);
		total_items++;
	endtask

	// request driver
	always @(negedge clk) begin
		div_req_t nxt;
		logic     v;
		v = drv_valid;
		if (arst_n && (!drv_valid || req_taken)) begin
			v = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (operand_queue.size() > 0 &&
			             !(operand_queue[0].drain && quotient_queue.size() > 0)) begin
				if (operand_queue.size() > TailItems && $urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(0, 14);
				end else begin
					nxt = operand_queue.pop_front();
					drv_op       <= nxt.op;
					drv_dividend <= nxt.dividend;
					drv_divisor  <= nxt.divisor;
					v = 1'b1;
				end
			end
		end
		drv_valid <= v;
	end

	// result receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		logic r;
		r = 1'b1;
		if (!arst_n) begin
			r = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			r = 1'b0;
		end else if (!hold_done && accepted_cnt >= HoldAt) begin
			hold_done = 1'b1;
			hold_left = HoldCycles - 1;
			r = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			r = 1'b0;
		end else if (operand_queue.size() > TailItems && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 14);
			r = 1'b0;
		end
		rsp_ready <= r;
	end

	// monitor: check results, then predict for the request taken at this edge
	always @(posedge clk) begin
		div_rsp_t want;
		if (arst_n) begin
			if (rsp.valid && rsp_ready) begin
				if (quotient_queue.size() == 0) begin
					$display("%0t: unexpected result quotient=%h status=%0d",
					         $time, rsp.quotient, rsp.status);
					mismatch_cnt++;
				end else begin
					want = quotient_queue.pop_front();
					result_cnt++;
					if (rsp.quotient !== want.quotient) begin
						$display("%0t: quotient mismatch: expected %h, got %h",
						         $time, want.quotient, rsp.quotient);
						mismatch_cnt++;
					end
					if (rsp.status !== want.status) begin
						$display("%0t: status mismatch: expected %0d, got %0d",
						         $time, want.status, rsp.status);
						mismatch_cnt++;
					end
				end
			end
			if (drv_valid && !req.ready)
				in_stall_cnt++;
			req_taken = drv_valid && req.ready;
			if (req_taken) begin
				want = rounded_quotient(drv_op, drv_dividend, drv_divisor);
				if (want.status == ST_SAT)
					sat_cnt++;
				if (want.status == ST_DIVZERO)
					divzero_cnt++;
				quotient_queue.push_back(want);
				accepted_cnt++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CycleLimit) begin
			$display("timeout after %0d cycles, %0d of %0d requests taken",
			         cycle_cnt, accepted_cnt, total_items);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		q16d_op_t op;
		logic [DataW-1:0] num;
		logic [DataW-1:0] den;

		// signed corners: most negative operand, overflow both ways, divide by zero
		queue_divide(OP_SIGNED, QOne, QOne);
		queue_divide(OP_SIGNED, SMinRaw, QOne);
		queue_divide(OP_SIGNED, SMinRaw, QIntMsk);
		queue_divide(OP_SIGNED, SMaxRaw, QOne);
		queue_divide(OP_SIGNED, SMinRaw, SMinRaw);
		queue_divide(OP_SIGNED, SMaxRaw, SMinRaw);
		queue_divide(OP_SIGNED, 32'h0001_8000, QIntMsk);
		queue_divide(OP_SIGNED, UMaxRaw, 32'h0000_0002);
		queue_divide(OP_SIGNED, QOne, '0);
		queue_divide(OP_SIGNED, QIntMsk, '0);
		queue_divide(OP_SIGNED, '0, '0);
		queue_divide(OP_SIGNED, '0, SMinRaw);
		queue_divide(OP_SIGNED, 32'h0000_0001, 32'h0000_0003);
		queue_divide(OP_SIGNED, SMaxRaw, 32'h0000_0001);
		// unsigned corners: full scale, overflow, divide by zero, rounding
		queue_divide(OP_UNSIGNED, UMaxRaw, UMaxRaw);
		queue_divide(OP_UNSIGNED, UMaxRaw, QOne);
		queue_divide(OP_UNSIGNED, UMaxRaw, 32'h0000_0001);
		queue_divide(OP_UNSIGNED, '0, '0);
		queue_divide(OP_UNSIGNED, SMinRaw, '0);
		queue_divide(OP_UNSIGNED, 32'h0000_0001, 32'h0000_0002);
		queue_divide(OP_UNSIGNED, 32'h0000_0003, 32'h0000_0002);
		queue_divide(OP_UNSIGNED, '0, UMaxRaw);
		queue_divide(OP_UNSIGNED, QIntMsk, 32'h0001_0001);
		queue_divide(OP_UNSIGNED, QOne, UMaxRaw);

		for (int i = 0; i < RandomItems; i++) begin
			op  = q16d_op_t'($urandom_range(0, 1));
			num = random_operand();
			den = random_operand();
			queue_divide(op, num, den, i == DrainAt);
		end

		// a real falling edge, so the asynchronous reset acts before the first clock
		#1;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_cnt < total_items || quotient_queue.size() > 0)
			@(negedge clk);
		repeat (FlushCycles) @(negedge clk);

		$display("%0d divide requests (signed and unsigned), %0d results checked",
		         accepted_cnt, result_cnt);
		$display("%0d saturated, %0d divide-by-zero, %0d cycles with input stalled",
		         sat_cnt, divzero_cnt, in_stall_cnt);
		if (mismatch_cnt == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
